### src/assert_macros.svh
// Assertion helpers shared by the filter modules.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define BF3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BF3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bf3_pkg.sv
`timescale 1ns / 1ps
package bf3_pkg;

    localparam int MAX_WIDTH            = 2048;
    localparam int RANGE_TABLE_DEPTH    = 4096;
    localparam int WEIGHT_FRACTION_BITS = 16;
    localparam int WINDOW_SIZE          = 9;

    localparam int LINE_AW  = $clog2(MAX_WIDTH);
    localparam int TAB_AW   = $clog2(RANGE_TABLE_DEPTH);
    localparam int WEIGHT_W = WEIGHT_FRACTION_BITS + 1;
    localparam int D2_W     = 18;
    localparam int SUM_W    = WEIGHT_W + 4;
    localparam int NUM_W    = WEIGHT_W + 8 + 4;
    localparam int REM_W    = NUM_W + 1;
    localparam int QUO_W    = 9;
    localparam int COL_W    = 11;
    localparam int ROW_W    = 12;
    localparam int CFG_W    = 13;
    localparam int PIX_W    = 24;

    // column limit: the smaller of the line store and the column field
    localparam int COL_LIMIT = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
    localparam int ROW_LIMIT = 4096;

    // exp(-1/200) in Q40, split in two 20-bit halves
    localparam logic [40:0] EXP_STEP_Q40 = 41'd1094027790655;
    localparam logic [19:0] EXP_HI = 20'(EXP_STEP_Q40 >> 20);
    localparam logic [19:0] EXP_LO = 20'(EXP_STEP_Q40 & 41'hFFFFF);

    // configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [PIX_W-1:0]    pixel_t;

    typedef struct packed {
        logic       accept;
        logic       shift;
        logic       clear;
        logic       issue;
        logic [3:0] issue_k;
        logic       div_load;
        logic       div_step;
        logic [3:0] div_i;
        logic       out_load;
    } bf3_cmd_t;

    typedef struct packed {
        logic table_ready;
        logic emit;
        logic out_room;
    } bf3_status_t;

    // spatial table index dx^2+dy^2 of a window slot
    function automatic logic [1:0] spatial_index(logic [3:0] k);
        logic [1:0] idx;
        case (k)
            4'd4:                      idx = 2'd0;
            4'd1, 4'd3, 4'd5, 4'd7:    idx = 2'd1;
            default:                   idx = 2'd2;
        endcase
        return idx;
    endfunction

endpackage

### src/bf3_ram.sv
`timescale 1ns / 1ps
module bf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### src/bf3_table_gen.sv
`timescale 1ns / 1ps
module bf3_table_gen (
    input  logic                        clk,
    input  logic                        rst_n,
    output logic                        wr_en,
    output logic [bf3_pkg::TAB_AW-1:0]  wr_addr,
    output bf3_pkg::weight_t            wr_data,
    output logic                        done,
    output bf3_pkg::weight_t            spatial_w [3]
);
    import bf3_pkg::*;

    typedef enum logic [2:0] {
        PH_LO_A,
        PH_LO_B,
        PH_HI_A,
        PH_HI_B,
        PH_STEP
    } phase_t;

    phase_t        phase_reg;
    logic [40:0]   acc_reg;
    logic [61:0]   s_reg;
    logic [TAB_AW:0] k_reg;
    logic          done_reg;
    weight_t       sw_reg [3];

    logic [20:0]   mul_a;
    logic [19:0]   mul_b;
    logic [40:0]   prod;
    weight_t       entry;
    logic [61:0]   s_next;
    logic [40:0]   acc_next;

    // pick the partial product for this phase
    always_comb
    begin
        case (phase_reg)
            PH_LO_A: begin mul_a = acc_reg[20:0];         mul_b = EXP_LO; end
            PH_LO_B: begin mul_a = {1'b0, acc_reg[40:21]}; mul_b = EXP_LO; end
            PH_HI_A: begin mul_a = acc_reg[20:0];         mul_b = EXP_HI; end
            PH_HI_B: begin mul_a = {1'b0, acc_reg[40:21]}; mul_b = EXP_HI; end
            default: begin mul_a = '0;                     mul_b = '0;     end
        endcase
        prod = 41'(mul_a * mul_b);
    end

    // round the Q40 value to the weight format
    assign entry = WEIGHT_W'((acc_reg + (41'd1 << (39 - WEIGHT_FRACTION_BITS)))
                             >> (40 - WEIGHT_FRACTION_BITS));

    always_comb
    begin
        s_next   = s_reg;
        acc_next = acc_reg;
        case (phase_reg)
            PH_LO_A: s_next = 62'(prod);
            PH_LO_B: s_next = s_reg + {prod, 21'b0};
            PH_HI_A: s_next = ((s_reg + 62'd524288) >> 20) + 62'(prod);
            PH_HI_B: s_next = s_reg + {prod, 21'b0};
            PH_STEP: acc_next = 41'((s_reg + 62'd524288) >> 20);
            default: s_next = s_reg;
        endcase
    end

    // step the recurrence, one entry per pass through the phases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LO_A;
            acc_reg   <= 41'd1 << 40;
            s_reg     <= '0;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else if (!done_reg)
        begin
            s_reg   <= s_next;
            acc_reg <= acc_next;
            if (phase_reg == PH_STEP)
            begin
                phase_reg <= PH_LO_A;
                k_reg     <= k_reg + 1'b1;
                done_reg  <= (k_reg == (TAB_AW+1)'(RANGE_TABLE_DEPTH - 1));
            end
            else
            begin
                phase_reg <= phase_t'(phase_reg + 3'd1);
            end
        end
    end

    // keep the first three entries for the spatial weights
    always_ff @(posedge clk)
    begin
        if (!done_reg && phase_reg == PH_LO_A && k_reg < (TAB_AW+1)'(3))
        begin
            sw_reg[k_reg[1:0]] <= entry;
        end
    end

    assign wr_en        = !done_reg && (phase_reg == PH_LO_A);
    assign wr_addr      = k_reg[TAB_AW-1:0];
    assign wr_data      = entry;
    assign done         = done_reg;
    assign spatial_w[0] = sw_reg[0];
    assign spatial_w[1] = sw_reg[1];
    assign spatial_w[2] = sw_reg[2];

endmodule

### src/bf3_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bf3_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bf3_pkg::bf3_cmd_t          cmd,
    output bf3_pkg::bf3_status_t       status,
    input  logic [7:0]                 blue_in,
    input  logic [7:0]                 green_in,
    input  logic [7:0]                 red_in,
    input  logic                       frame_start,
    input  logic                       cfg_write,
    input  logic                       cfg_index,
    input  logic [bf3_pkg::CFG_W-1:0]  cfg_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 blue_out,
    output logic [7:0]                 green_out,
    output logic [7:0]                 red_out,
    output logic [bf3_pkg::ROW_W-1:0]  out_row,
    output logic [bf3_pkg::COL_W-1:0]  out_col,
    output logic                       last_of_frame
);
    import bf3_pkg::*;

    // configuration
    logic [11:0]      width_reg;
    logic [12:0]      height_reg;
    logic [11:0]      eff_w;
    logic [12:0]      eff_h;

    // position and current item
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] c_cur_reg;
    logic [ROW_W-1:0] r_cur_reg;
    pixel_t           px_reg;
    logic [COL_W-1:0] col_sel;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;

    // line stores and window
    pixel_t           one_up_rd;
    pixel_t           two_up_rd;
    pixel_t           win_reg [WINDOW_SIZE];
    pixel_t           centre;

    // weight table
    logic                 tab_we;
    logic [TAB_AW-1:0]    tab_waddr;
    weight_t              tab_wdata;
    weight_t              tab_rd;
    logic                 table_done;
    weight_t              spatial_w [3];

    // weight pipeline
    pixel_t               probe;
    logic [D2_W-1:0]      d2;
    logic                 s1_valid_reg;
    logic [TAB_AW-1:0]    s1_addr_reg;
    logic                 s1_far_reg;
    pixel_t               s1_px_reg;
    logic [1:0]           s1_sidx_reg;
    logic                 s2_valid_reg;
    logic                 s2_far_reg;
    pixel_t               s2_px_reg;
    logic [1:0]           s2_sidx_reg;
    weight_t              rw;
    logic [2*WEIGHT_W-1:0] wprod;
    logic                 s3_valid_reg;
    weight_t              wgt_reg;
    pixel_t               s3_px_reg;

    // sums and division
    logic [SUM_W-1:0]     sum_reg;
    logic [NUM_W-1:0]     num_reg [3];
    logic [REM_W-1:0]     rem_reg [3];
    logic [QUO_W-1:0]     quo_reg [3];
    logic [REM_W-1:0]     shifted;

    logic                 out_valid_reg;
    logic [7:0]           chan_out [3];

    function automatic logic [15:0] sq_diff(logic [7:0] a, logic [7:0] b);
        logic signed [8:0]  d;
        logic signed [17:0] p;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        p = d * d;
        return p[15:0];
    endfunction

    // clamp the frame size
    always_comb
    begin
        eff_w = width_reg;
        if (eff_w < 12'd3)
            eff_w = 12'd3;
        if (eff_w > 12'(COL_LIMIT))
            eff_w = 12'(COL_LIMIT);
        eff_h = height_reg;
        if (eff_h < 13'd3)
            eff_h = 13'd3;
        if (eff_h > 13'(ROW_LIMIT))
            eff_h = 13'(ROW_LIMIT);
    end

    // take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd640;
            height_reg <= 13'd480;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[11:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    assign col_sel = frame_start ? '0 : col_reg;

    // next position after the current item
    always_comb
    begin
        if ({1'b0, c_cur_reg} + 12'd1 >= eff_w)
        begin
            col_next = '0;
            row_next = ({1'b0, r_cur_reg} + 13'd1 >= eff_h) ? '0 : r_cur_reg + 1'b1;
        end
        else
        begin
            col_next = c_cur_reg + 1'b1;
            row_next = r_cur_reg;
        end
    end

    // hold the item and its position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            c_cur_reg <= '0;
            r_cur_reg <= '0;
        end
        else if (cmd.accept)
        begin
            c_cur_reg <= col_sel;
            r_cur_reg <= frame_start ? '0 : row_reg;
        end
        else if (cmd.shift)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            px_reg <= {red_in, green_in, blue_in};
    end

    bf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_one (
        .clk   (clk),
        .we    (cmd.shift),
        .waddr (LINE_AW'(c_cur_reg)),
        .wdata (px_reg),
        .raddr (LINE_AW'(col_sel)),
        .rdata (one_up_rd)
    );

    bf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_two (
        .clk   (clk),
        .we    (cmd.shift),
        .waddr (LINE_AW'(c_cur_reg)),
        .wdata (one_up_rd),
        .raddr (LINE_AW'(col_sel)),
        .rdata (two_up_rd)
    );

    // advance the window by one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_SIZE; i++)
                win_reg[i] <= '0;
        end
        else if (cmd.shift)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= two_up_rd;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= one_up_rd;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= px_reg;
        end
    end

    assign centre = win_reg[4];

    bf3_table_gen u_table_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (tab_we),
        .wr_addr   (tab_waddr),
        .wr_data   (tab_wdata),
        .done      (table_done),
        .spatial_w (spatial_w)
    );

    bf3_ram #(.WIDTH(WEIGHT_W), .DEPTH(RANGE_TABLE_DEPTH)) u_weight_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (s1_addr_reg),
        .rdata (tab_rd)
    );

    // stage one: colour distance of one neighbour
    assign probe = win_reg[cmd.issue_k];
    assign d2 = D2_W'(sq_diff(probe[7:0],   centre[7:0]))
              + D2_W'(sq_diff(probe[15:8],  centre[15:8]))
              + D2_W'(sq_diff(probe[23:16], centre[23:16]));

    // stage three: product weight
    assign rw    = s2_far_reg ? '0 : tab_rd;
    assign wprod = (2*WEIGHT_W)'(spatial_w[s2_sidx_reg]) * (2*WEIGHT_W)'(rw);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= d2[TAB_AW-1:0];
        s1_far_reg  <= (d2 >= D2_W'(RANGE_TABLE_DEPTH));
        s1_px_reg   <= probe;
        s1_sidx_reg <= spatial_index(cmd.issue_k);
        s2_far_reg  <= s1_far_reg;
        s2_px_reg   <= s1_px_reg;
        s2_sidx_reg <= s1_sidx_reg;
        wgt_reg     <= WEIGHT_W'((wprod + (2*WEIGHT_W)'(1 << (WEIGHT_FRACTION_BITS - 1)))
                                 >> WEIGHT_FRACTION_BITS);
        s3_px_reg   <= s2_px_reg;
    end

    // stage four: accumulate weight and weighted channels
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            sum_reg <= '0;
            for (int ch = 0; ch < 3; ch++)
                num_reg[ch] <= '0;
        end
        else if (s3_valid_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(wgt_reg);
            for (int ch = 0; ch < 3; ch++)
                num_reg[ch] <= num_reg[ch]
                             + NUM_W'(wgt_reg) * NUM_W'(s3_px_reg[8*ch +: 8]);
        end
    end

    // restoring division, one quotient bit per cycle in each channel
    assign shifted = REM_W'(sum_reg) << cmd.div_i;

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                rem_reg[ch] <= REM_W'(num_reg[ch]) + REM_W'(sum_reg >> 1);
                quo_reg[ch] <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                if (rem_reg[ch] >= shifted)
                begin
                    rem_reg[ch]              <= rem_reg[ch] - shifted;
                    quo_reg[ch][cmd.div_i]   <= 1'b1;
                end
            end
        end
    end

    // saturate to a byte
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
            chan_out[ch] = (quo_reg[ch] > QUO_W'(255)) ? 8'd255 : quo_reg[ch][7:0];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            blue_out      <= chan_out[0];
            green_out     <= chan_out[1];
            red_out       <= chan_out[2];
            out_row       <= r_cur_reg - 1'b1;
            out_col       <= c_cur_reg - 1'b1;
            last_of_frame <= ({1'b0, r_cur_reg} == eff_h - 13'd1)
                          && ({1'b0, c_cur_reg} == eff_w - 12'd1);
        end
    end

    assign out_valid          = out_valid_reg;
    assign status.table_ready = table_done;
    assign status.emit        = (r_cur_reg >= ROW_W'(2)) && (c_cur_reg >= COL_W'(2));
    assign status.out_room    = !out_valid_reg || !out_stall;

    `BF3_ASSERT_NEXT(a_out_from_load, !out_valid_reg && !cmd.out_load, !out_valid_reg,
        "result appeared without a load")
    `BF3_ASSERT_NOW(a_issue_after_build, cmd.issue || cmd.accept, table_done,
        "weight table used before it was built")

endmodule

### src/bf3_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bf3_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output bf3_pkg::bf3_cmd_t     cmd,
    input  bf3_pkg::bf3_status_t  status
);
    import bf3_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SHIFT,
        ST_ACCUM,
        ST_DRAIN,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t     state_reg;
    logic [3:0] cnt_reg;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_INIT:
                    if (status.table_ready)
                        state_reg <= ST_IDLE;
                ST_IDLE:
                    if (in_valid)
                        state_reg <= ST_SHIFT;
                ST_SHIFT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= status.emit ? ST_ACCUM : ST_IDLE;
                end
                ST_ACCUM:
                begin
                    if (cnt_reg == 4'(WINDOW_SIZE - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 4'd2)
                        state_reg <= ST_DIV_LOAD;
                end
                ST_DIV_LOAD:
                begin
                    cnt_reg   <= 4'(QUO_W - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                    if (status.out_room)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_INIT;
            endcase
        end
    end

    // decode commands
    always_comb
    begin
        cmd          = '0;
        cmd.accept   = (state_reg == ST_IDLE) && in_valid;
        cmd.shift    = (state_reg == ST_SHIFT);
        cmd.clear    = (state_reg == ST_SHIFT);
        cmd.issue    = (state_reg == ST_ACCUM);
        cmd.issue_k  = cnt_reg;
        cmd.div_load = (state_reg == ST_DIV_LOAD);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.div_i    = cnt_reg;
        cmd.out_load = (state_reg == ST_DONE) && status.out_room;
    end

    assign in_stall = (state_reg != ST_IDLE);

    `BF3_ASSERT_NOW(a_issue_in_window, cmd.issue, cnt_reg <= 4'(WINDOW_SIZE - 1),
        "neighbour index beyond the window")
    `BF3_ASSERT_NEXT(a_accept_then_shift, cmd.accept, state_reg == ST_SHIFT,
        "accepted item not shifted in")

endmodule

### src/bilateral_filter_3x3_rgb_unit.sv
`timescale 1ns / 1ps
// Flow: each accepted item is shifted into the window; one that completes a 3x3 window
// then makes nine table reads through the single weight memory port, drains the weight
// pipeline, runs the 9-step divider and waits for output room; in_stall stays high until
// the item is done. Reset at once clears counters and window and sets the frame size to
// 640x480; the weight table is then built, during which in_stall stays high.
module bilateral_filter_3x3_rgb_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 blue_in,
    input  logic [7:0]                 green_in,
    input  logic [7:0]                 red_in,
    input  logic                       frame_start,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 blue_out,
    output logic [7:0]                 green_out,
    output logic [7:0]                 red_out,
    output logic [bf3_pkg::ROW_W-1:0]  out_row,
    output logic [bf3_pkg::COL_W-1:0]  out_col,
    output logic                       last_of_frame,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [bf3_pkg::CFG_W-1:0]  cfg_data
);
    import bf3_pkg::*;

    bf3_cmd_t    cmd;
    bf3_status_t status;

    assign cfg_ready = 1'b1;

    bf3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    bf3_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .blue_in       (blue_in),
        .green_in      (green_in),
        .red_in        (red_in),
        .frame_start   (frame_start),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .blue_out      (blue_out),
        .green_out     (green_out),
        .red_out       (red_out),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_of_frame (last_of_frame)
    );

endmodule

### verif/tb_bilateral_filter_3x3_rgb_unit.sv
`timescale 1ns / 1ps
module tb_bilateral_filter_3x3_rgb_unit;
    import bf3_pkg::*;

    localparam int STALL_LIMIT = 60000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        bit [7:0]       blue;
        bit [7:0]       green;
        bit [7:0]       red;
        bit [ROW_W-1:0] row;
        bit [COL_W-1:0] col;
        bit             last;
    } filt_px_t;

    // Predicts filtered pixels from accepted items and checks the block's results
    class filter_scoreboard;
        int unsigned exp_weight[RANGE_TABLE_DEPTH];
        bit [23:0]   line_one[MAX_WIDTH];
        bit [23:0]   line_two[MAX_WIDTH];
        bit [23:0]   win[9];
        int unsigned col_cnt;
        int unsigned row_cnt;
        int unsigned width_reg;
        int unsigned height_reg;
        filt_px_t    pending_pixels[$];
        int          mismatches;

        function new();
            longint unsigned acc, part;
            longint unsigned hi, lo;
            acc = 64'd1 << 40;
            hi = EXP_HI;
            lo = EXP_LO;
            for (int k = 0; k < RANGE_TABLE_DEPTH; k++)
            begin
                exp_weight[k] = int'((acc + (64'd1 << (39 - WEIGHT_FRACTION_BITS)))
                                     >> (40 - WEIGHT_FRACTION_BITS));
                part = acc * hi + ((acc * lo + (64'd1 << 19)) >> 20);
                acc = (part + (64'd1 << 19)) >> 20;
            end
            foreach (line_one[i])
            begin
                line_one[i] = '0;
                line_two[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            col_cnt = 0;
            row_cnt = 0;
            width_reg = 640;
            height_reg = 480;
            mismatches = 0;
        endfunction

        function void write_reg(logic idx, int unsigned value);
            if (idx == CFG_IMAGE_WIDTH)
                width_reg = value & 12'hFFF;
            else
                height_reg = value & 13'h1FFF;
        endfunction

        // Advance the window for one accepted item and queue any filtered pixel
        function void note_pixel(bit [7:0] b, bit [7:0] g, bit [7:0] r, bit fs);
            int unsigned w, h, c, rr, d2, rw, sp;
            bit [23:0] px, top, mid, centre, p;
            bit [23:0] col_in[3];
            longint unsigned wgt, total, v;
            longint unsigned num[3];
            int d;
            filt_px_t res;
            w = (width_reg < 3) ? 3 : ((width_reg > COL_LIMIT) ? COL_LIMIT : width_reg);
            h = (height_reg < 3) ? 3 : ((height_reg > ROW_LIMIT) ? ROW_LIMIT : height_reg);
            px = {r, g, b};
            top = '0;
            mid = '0;
            if (fs)
            begin
                col_cnt = 0;
                row_cnt = 0;
            end
            c = col_cnt;
            rr = row_cnt;
            if (c < MAX_WIDTH)
            begin
                top = line_two[c];
                mid = line_one[c];
                line_two[c] = mid;
                line_one[c] = px;
            end
            col_in[0] = top;
            col_in[1] = mid;
            col_in[2] = px;
            for (int i = 0; i < 3; i++)
            begin
                win[i*3] = win[i*3+1];
                win[i*3+1] = win[i*3+2];
                win[i*3+2] = col_in[i];
            end
            if (rr >= 2 && c >= 2)
            begin
                centre = win[4];
                total = 0;
                num = '{0, 0, 0};
                for (int k = 0; k < 9; k++)
                begin
                    p = win[k];
                    sp = ((k / 3 == 1) ? 0 : 1) + ((k % 3 == 1) ? 0 : 1);
                    d2 = 0;
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        d = int'(p[8*ch +: 8]) - int'(centre[8*ch +: 8]);
                        d2 += d * d;
                    end
                    rw = (d2 < RANGE_TABLE_DEPTH) ? exp_weight[d2] : 0;
                    wgt = (longint'(exp_weight[sp]) * rw
                           + (64'd1 << (WEIGHT_FRACTION_BITS - 1))) >> WEIGHT_FRACTION_BITS;
                    total += wgt;
                    for (int ch = 0; ch < 3; ch++)
                        num[ch] += wgt * p[8*ch +: 8];
                end
                v = total ? (num[0] + total / 2) / total : 0;
                res.blue = (v > 255) ? 8'd255 : v[7:0];
                v = total ? (num[1] + total / 2) / total : 0;
                res.green = (v > 255) ? 8'd255 : v[7:0];
                v = total ? (num[2] + total / 2) / total : 0;
                res.red = (v > 255) ? 8'd255 : v[7:0];
                res.row = ROW_W'(rr - 1);
                res.col = COL_W'(c - 1);
                res.last = (rr == h - 1 && c == w - 1);
                pending_pixels.push_back(res);
            end
            if (c + 1 >= w)
            begin
                col_cnt = 0;
                row_cnt = (rr + 1 >= h) ? 0 : ((rr + 1) & 12'hFFF);
            end
            else
                col_cnt = (c + 1) & 11'h7FF;
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_pixel(filt_px_t got);
            filt_px_t want;
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: b=%0d g=%0d r=%0d row=%0d col=%0d last=%0d",
                             got.blue, got.green, got.red, got.row, got.col, got.last);
                return;
            end
            want = pending_pixels.pop_front();
            if (got != want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected b=%0d g=%0d r=%0d row=%0d col=%0d last=%0d,",
                             want.blue, want.green, want.red, want.row, want.col, want.last,
                             " got b=%0d g=%0d r=%0d row=%0d col=%0d last=%0d",
                             got.blue, got.green, got.red, got.row, got.col, got.last);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [7:0]          blue_in;
    logic [7:0]          green_in;
    logic [7:0]          red_in;
    logic                frame_start;
    logic                out_valid;
    logic                out_stall;
    logic [7:0]          blue_out;
    logic [7:0]          green_out;
    logic [7:0]          red_out;
    logic [ROW_W-1:0]    out_row;
    logic [COL_W-1:0]    out_col;
    logic                last_of_frame;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    filter_scoreboard sb;
    bit   steady;
    bit   hold_request;
    int   quiet_cycles;
    int   pixels_sent;
    int   base_b, base_g, base_r, spread;

    bilateral_filter_3x3_rgb_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .blue_in(blue_in), .green_in(green_in), .red_in(red_in),
        .frame_start(frame_start),
        .out_valid(out_valid), .out_stall(out_stall),
        .blue_out(blue_out), .green_out(green_out), .red_out(red_out),
        .out_row(out_row), .out_col(out_col), .last_of_frame(last_of_frame),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // Sample results, then choose the next stall state
    int stall_left;
    int hold_left;
    always @(posedge clk)
    begin
        filt_px_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.blue = blue_out;
            got.green = green_out;
            got.red = red_out;
            got.row = out_row;
            got.col = out_col;
            got.last = last_of_frame;
            sb.check_pixel(got);
        end
        if (hold_request && hold_left == 0)
        begin
            hold_request <= 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!steady && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic idx, int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // Let every predicted pixel arrive, then allow the pipeline to settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        drain();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    task automatic send_pixel(bit [7:0] b, bit [7:0] g, bit [7:0] r, bit fs);
        int gap;
        if (!steady && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        blue_in <= b;
        green_in <= g;
        red_in <= r;
        frame_start <= fs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_pixel(b, g, r, fs);
        pixels_sent++;
    endtask

    function automatic bit [7:0] near_base(int base);
        int v;
        v = base + $urandom_range(0, 2 * spread) - spread;
        return (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : v[7:0]);
    endfunction

    // Send a run of frames: mostly textured patches, some fully random pixels,
    // and now and then a stray frame start
    task automatic send_frames(int unsigned w, int unsigned h, int frames);
        bit fs;
        for (int f = 0; f < frames; f++)
        begin
            base_b = $urandom_range(0, 255);
            base_g = $urandom_range(0, 255);
            base_r = $urandom_range(0, 255);
            for (int i = 0; i < w * h; i++)
            begin
                if (i % 7 == 0)
                    spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60)
                                                         : $urandom_range(0, 12);
                fs = (i == 0) || ($urandom_range(0, 499) == 0);
                if ($urandom_range(0, 9) == 0)
                    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), fs);
                else
                    send_pixel(near_base(base_b), near_base(base_g), near_base(base_r), fs);
            end
        end
    endtask

    initial
    begin
        int unsigned w, h;
        sb = new();
        steady = 1'b0;
        hold_request = 1'b0;
        quiet_cycles = 0;
        pixels_sent = 0;
        stall_left = 0;
        hold_left = 0;
        in_valid <= 1'b0;
        blue_in <= '0;
        green_in <= '0;
        red_in <= '0;
        frame_start <= 1'b0;
        out_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data <= '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: smallest frame clamped up from zero, extreme colours
        write_reg(CFG_IMAGE_WIDTH, 0);
        write_reg(CFG_IMAGE_HEIGHT, 0);
        for (int i = 0; i < 9; i++)
            send_pixel((i == 4) ? 8'd0 : 8'd255, (i % 2) ? 8'd255 : 8'd0,
                       (i == 4) ? 8'd255 : 8'd0, i == 0);
        // uniform window: every range weight is one
        for (int i = 0; i < 9; i++)
            send_pixel(8'd128, 8'd128, 8'd128, i == 0);
        // near colours inside the table and one neighbour just past it
        for (int i = 0; i < 9; i++)
            send_pixel((i == 0) ? 8'd168 : 8'(100 + i), 8'd50, 8'(200 - i), i == 0);

        // Random small frames across several sizes
        set_size(1, 4);
        send_frames(3, 4, 3);
        set_size(5, 3);
        send_frames(5, 3, 4);
        hold_request = 1'b1;
        send_frames(5, 3, 6);
        set_size(17, 6);
        send_frames(17, 6, 2);
        while (pixels_sent < 800)
        begin
            w = $urandom_range(3, 24);
            h = $urandom_range(3, 9);
            set_size(w | ($urandom_range(0, 1) << 12), h);
            send_frames(w, h, $urandom_range(1, 3));
        end

        // Widest line setting with part of a first row, then the tallest frame
        // setting with a partial frame
        set_size(4095, 3);
        send_frames(300, 1, 1);
        set_size(4, 8191);
        send_frames(4, 40, 1);

        // Final stretch with no idling on either side
        set_size(9, 5);
        steady = 1'b1;
        send_frames(9, 5, 6);
        drain();

        if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

### sim.f
+incdir+src
src/bf3_pkg.sv
src/bf3_ram.sv
src/bf3_table_gen.sv
src/bf3_datapath.sv
src/bf3_ctrl.sv
src/bilateral_filter_3x3_rgb_unit.sv
verif/tb_bilateral_filter_3x3_rgb_unit.sv
